>>> rtl/rss_pkg.sv
// Shared types and constants of the retransmit slot scheduler.
// Used by the controller, the datapath, the top level and the checker.
package rss_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REQ,
    ST_SCAN
  } state_t;

  localparam logic [1:0] EV_TX      = 2'd0;
  localparam logic [1:0] EV_QUEUED  = 2'd1;
  localparam logic [1:0] EV_DROPPED = 2'd2;

  localparam logic [1:0] CFG_COPIES = 2'd0;
  localparam logic [1:0] CFG_JITTER = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  localparam logic [2:0]  COPIES_RST   = 3'd3;
  localparam logic [7:0]  JITTER_RST   = 8'd5;
  localparam logic [15:0] SEED_DEFAULT = 16'd44257;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  typedef struct packed {
    logic capture;
    logic eval;
    logic req_exec;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic due_cur;
    logic mask_empty;
    logic out_free;
  } status_t;

endpackage

>>> rtl/rss_ctrl.sv
// Controller state machine of the retransmit slot scheduler.
// Depends on rss_pkg for the state type and the command and status structs.
module rss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rss_pkg::status_t status,
  output rss_pkg::cmd_t    cmd
);

  rss_pkg::state_t state_r;
  rss_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rss_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rss_pkg::ST_EVAL;
      end
      rss_pkg::ST_EVAL: begin
        state_nxt = status.is_tick ? rss_pkg::ST_SCAN : rss_pkg::ST_REQ;
      end
      rss_pkg::ST_REQ: begin
        if (status.out_free) state_nxt = rss_pkg::ST_IDLE;
      end
      rss_pkg::ST_SCAN: begin
        if (status.mask_empty) state_nxt = rss_pkg::ST_IDLE;
      end
      default: state_nxt = rss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd          = '0;
    unique case (state_r)
      rss_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      rss_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      rss_pkg::ST_REQ: begin
        cmd.req_exec = status.out_free;
      end
      rss_pkg::ST_SCAN: begin
        if (!status.mask_empty) begin
          if (status.due_cur) begin
            cmd.emit    = status.out_free;
            cmd.advance = status.out_free;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/rss_datapath.sv
// Datapath of the retransmit slot scheduler: slot table, jitter LFSR,
// configuration registers and the result register. Depends on rss_pkg.
module rss_datapath #(
  parameter int SLOTS    = 4,
  parameter int TAG_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rss_pkg::cmd_t    cmd,
  output rss_pkg::status_t status,
  input  logic             in_kind,
  input  logic [15:0]      in_packet_tag,
  input  logic [31:0]      in_now_ms,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_event_res,
  output logic [15:0]      out_tag_out,
  output logic [1:0]       out_slot_index,
  output logic [2:0]       out_copies_left,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;

  logic             kind_r;
  logic [TW-1:0]    tag_r;
  logic [31:0]      now_r;
  logic [SLOTS-1:0] due_mask_r;
  logic [IW-1:0]    idx_r;

  logic [TW-1:0]    slot_tag_r [SLOTS];
  logic [2:0]       slot_rem_r [SLOTS];
  logic [31:0]      slot_due_r [SLOTS];

  logic [2:0]       copies_r;
  logic [7:0]       jitter_r;
  logic [15:0]      lfsr_r;

  logic             out_valid_r;
  logic [1:0]       out_event_r;
  logic [15:0]      out_tag_r;
  logic [1:0]       out_slot_r;
  logic [2:0]       out_left_r;
  logic             out_last_r;

  logic [SLOTS-1:0] due_mask;
  logic [SLOTS-1:0] mask_rest;
  logic [IW-1:0]    free_idx;
  logic             free_found;
  logic [2:0]       full_cnt;
  logic [2:0]       rem_dec;
  logic [15:0]      lfsr_shift;
  logic [31:0]      new_due;
  logic             out_free;
  logic [IW+1:0]    cur_idx_ext;
  logic [IW+1:0]    free_idx_ext;
  logic [TW+15:0]   cur_tag_ext;
  logic [TW+15:0]   req_tag_ext;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      due_mask[i] = (slot_rem_r[i] != 3'd0) && (now_r >= slot_due_r[i]);
    end
  end

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_rem_r[i] == 3'd0) begin
        free_idx   = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    mask_rest        = due_mask_r;
    mask_rest[idx_r] = 1'b0;
  end

  assign full_cnt     = (copies_r == 3'd0) ? 3'd1 : copies_r;
  assign rem_dec      = slot_rem_r[idx_r] - 3'd1;
  assign lfsr_shift   = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? rss_pkg::LFSR_TAPS : 16'd0);
  assign new_due      = now_r + {24'd0, jitter_r} + {28'd0, lfsr_shift[3:0]};
  assign out_free     = !out_valid_r || !out_stall;
  assign cur_idx_ext  = {2'b00, idx_r};
  assign free_idx_ext = {2'b00, free_idx};
  assign cur_tag_ext  = {16'd0, slot_tag_r[idx_r]};
  assign req_tag_ext  = {16'd0, tag_r};

  assign status.is_tick    = kind_r;
  assign status.due_cur    = due_mask_r[idx_r];
  assign status.mask_empty = (due_mask_r == '0);
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      tag_r  <= in_packet_tag[TW-1:0];
      now_r  <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_mask_r <= '0;
      idx_r      <= '0;
    end else if (cmd.eval) begin
      due_mask_r <= kind_r ? due_mask : '0;
      idx_r      <= '0;
    end else if (cmd.advance) begin
      due_mask_r[idx_r] <= 1'b0;
      idx_r             <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_rem_r[i] <= 3'd0;
    end else if (cmd.req_exec && free_found) begin
      slot_rem_r[free_idx] <= full_cnt;
    end else if (cmd.emit) begin
      slot_rem_r[idx_r] <= rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_exec && free_found) begin
      slot_tag_r[free_idx] <= tag_r;
      slot_due_r[free_idx] <= now_r;
    end else if (cmd.emit && rem_dec != 3'd0) begin
      slot_due_r[idx_r] <= new_due;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copies_r <= rss_pkg::COPIES_RST;
      jitter_r <= rss_pkg::JITTER_RST;
      lfsr_r   <= rss_pkg::SEED_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rss_pkg::CFG_COPIES: copies_r <= cfg_wdata[2:0];
        rss_pkg::CFG_JITTER: jitter_r <= cfg_wdata[7:0];
        rss_pkg::CFG_SEED:
          lfsr_r <= (cfg_wdata == 16'd0) ? rss_pkg::SEED_DEFAULT : cfg_wdata;
        default: ;
      endcase
    end else if (cmd.emit && rem_dec != 3'd0) begin
      lfsr_r <= lfsr_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.req_exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_event_r <= rss_pkg::EV_TX;
      out_tag_r   <= cur_tag_ext[15:0];
      out_slot_r  <= cur_idx_ext[1:0];
      out_left_r  <= rem_dec;
      out_last_r  <= (mask_rest == '0);
    end else if (cmd.req_exec) begin
      out_tag_r  <= req_tag_ext[15:0];
      out_last_r <= 1'b1;
      if (free_found) begin
        out_event_r <= rss_pkg::EV_QUEUED;
        out_slot_r  <= free_idx_ext[1:0];
        out_left_r  <= full_cnt;
      end else begin
        out_event_r <= rss_pkg::EV_DROPPED;
        out_slot_r  <= 2'd0;
        out_left_r  <= 3'd0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_tag_out     = out_tag_r;
  assign out_slot_index  = out_slot_r;
  assign out_copies_left = out_left_r;
  assign out_last        = out_last_r;

endmodule

>>> rtl/retransmit_slot_scheduler.sv
// Retransmit slot scheduler, top level: joins the controller and the datapath.
// A send request gives its one result, which the REQ state loads into the result register once it is free.
// A tick runs the scan that visits one slot per cycle until no due slot is left.
// Each due slot gives one transaction; a stalled result register holds the scan.
// Synchronous active-low reset frees every slot, restores the configuration
// and loads the default seed into the LFSR.
module retransmit_slot_scheduler #(
  parameter int SLOTS    = 4,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_packet_tag,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [15:0] out_tag_out,
  output logic [1:0]  out_slot_index,
  output logic [2:0]  out_copies_left,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  rss_pkg::cmd_t    cmd;
  rss_pkg::status_t status;

  rss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rss_datapath #(
    .SLOTS    (SLOTS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_kind),
    .in_packet_tag   (in_packet_tag),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_res   (out_event_res),
    .out_tag_out     (out_tag_out),
    .out_slot_index  (out_slot_index),
    .out_copies_left (out_copies_left),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

endmodule

>>> rtl/rss_checker.sv
// Port-level checker of the retransmit slot scheduler, bound to the top level.
// Depends on rss_pkg for the event codes.
module rss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_res,
  input logic [15:0] out_tag_out,
  input logic [1:0]  out_slot_index,
  input logic [2:0]  out_copies_left,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tag_out) && $stable(out_last)
      && $stable(out_event_res) && $stable(out_slot_index) && $stable(out_copies_left))
    else $error("Stalled result transaction changed.");

  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Input accepted while the previous transaction was still in work.");

  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == rss_pkg::EV_DROPPED |->
      out_slot_index == 2'd0 && out_copies_left == 3'd0 && out_last)
    else $error("Dropped request carries slot or count.");

  a_request_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == rss_pkg::EV_QUEUED |-> out_last && out_copies_left != 3'd0)
    else $error("Queued request result malformed.");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res == rss_pkg::EV_TX || out_event_res == rss_pkg::EV_QUEUED
      || out_event_res == rss_pkg::EV_DROPPED)
    else $error("Unknown event code on the result channel.");

endmodule

bind retransmit_slot_scheduler rss_checker u_rss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_event_res   (out_event_res),
  .out_tag_out     (out_tag_out),
  .out_slot_index  (out_slot_index),
  .out_copies_left (out_copies_left),
  .out_last        (out_last)
);

>>> tb/sv/tb_retransmit_slot_scheduler.sv
`timescale 1ns / 100ps
// Self-checking testbench of the retransmit slot scheduler: send requests and time ticks
// go in under random idling, and every outgoing transaction is predicted and compared.
// Depends on rss_pkg and the retransmit_slot_scheduler RTL only.
module tb_retransmit_slot_scheduler;

  localparam int SLOTS = 4;
  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam int MAX_GAP = 12;
  localparam int SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        kind;
    logic [15:0] tag;
    logic [31:0] now;
  } sched_item_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [15:0] tag;
    logic [1:0]  slot;
    logic [2:0]  left;
    logic        last;
  } sched_evt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [15:0] in_packet_tag = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_res;
  logic [15:0] out_tag_out;
  logic [1:0]  out_slot_index;
  logic [2:0]  out_copies_left;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rss_pkg::CFG_COPIES;
  logic [15:0] cfg_wdata = '0;

  logic [15:0] slot_tag_m [SLOTS];
  logic [2:0]  slot_left_m [SLOTS];
  logic [31:0] slot_due_m [SLOTS];
  logic [15:0] lfsr_m;
  logic [2:0]  copies_m;
  logic [7:0]  jitter_m;

  sched_item_t pending_items[$];
  sched_evt_t  expected_evts[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  logic [31:0] clock_ms;

  retransmit_slot_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_packet_tag(in_packet_tag), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_event_res(out_event_res),
    .out_tag_out(out_tag_out), .out_slot_index(out_slot_index),
    .out_copies_left(out_copies_left), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [3:0] jitter_draw();
    logic shifted_out;
    shifted_out = lfsr_m[0];
    lfsr_m = lfsr_m >> 1;
    if (shifted_out) lfsr_m = lfsr_m ^ rss_pkg::LFSR_TAPS;
    return lfsr_m[3:0];
  endfunction

  // Works out the transactions that one accepted item causes and updates the slot table.
  function automatic void predict_slots(logic kind, logic [15:0] tag, logic [31:0] now);
    sched_evt_t evt;
    logic [2:0] full;
    logic placed;
    int i;
    int due_count;
    int emitted;
    if (kind == KIND_SEND) begin
      full = (copies_m == 3'd0) ? 3'd1 : copies_m;
      evt = sched_evt_t'{rss_pkg::EV_DROPPED, tag, 2'd0, 3'd0, 1'b1};
      placed = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
        if (!placed && slot_left_m[i] == 3'd0) begin
          slot_tag_m[i] = tag;
          slot_left_m[i] = full;
          slot_due_m[i] = now;
          evt = sched_evt_t'{rss_pkg::EV_QUEUED, tag, 2'(i), full, 1'b1};
          placed = 1'b1;
        end
      end
      expected_evts.push_back(evt);
    end else begin
      due_count = 0;
      for (i = 0; i < SLOTS; i++)
        if (slot_left_m[i] != 3'd0 && now >= slot_due_m[i]) due_count++;
      emitted = 0;
      for (i = 0; i < SLOTS; i++) begin
        if (slot_left_m[i] != 3'd0 && now >= slot_due_m[i]) begin
          slot_left_m[i] = slot_left_m[i] - 3'd1;
          if (slot_left_m[i] != 3'd0)
            slot_due_m[i] = 32'(now + {24'd0, jitter_m} + {28'd0, jitter_draw()});
          emitted++;
          expected_evts.push_back(sched_evt_t'{rss_pkg::EV_TX, slot_tag_m[i], 2'(i),
                                               slot_left_m[i], emitted == due_count});
        end
      end
    end
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("mismatch in %s: expected %0h, got %0h at %0t", name, want, got, $realtime);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[retransmit_slot_scheduler] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    sched_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) predict_slots(in_kind, in_packet_tag, in_now_ms);
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          nxt = pending_items.pop_front();
          in_kind <= nxt.kind;
          in_packet_tag <= nxt.tag;
          in_now_ms <= nxt.now;
          in_valid <= 1'b1;
          in_gap <= in_calm ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sched_evt_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_evts.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected transaction: event %0d tag %0h at %0t",
                     out_event_res, out_tag_out, $realtime);
          mismatches++;
        end else begin
          want = expected_evts.pop_front();
          field_check("event_res", 32'(want.ev), 32'(out_event_res));
          field_check("tag_out", 32'(want.tag), 32'(out_tag_out));
          field_check("slot_index", 32'(want.slot), 32'(out_slot_index));
          field_check("copies_left", 32'(want.left), 32'(out_copies_left));
          field_check("last", 32'(want.last), 32'(out_last));
        end
        out_hold = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (out_hold != 0) begin
        out_stall <= 1'b1;
        out_hold = out_hold - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_item(logic kind, logic [15:0] tag, logic [31:0] now);
    pending_items.push_back(sched_item_t'{kind, tag, now});
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      rss_pkg::CFG_COPIES: copies_m = val[2:0];
      rss_pkg::CFG_JITTER: jitter_m = val[7:0];
      default: lfsr_m = (val == 16'd0) ? rss_pkg::SEED_DEFAULT : val;
    endcase
  endtask

  task automatic configure(logic [2:0] copies, logic [7:0] jitter, logic [15:0] seed);
    write_reg(rss_pkg::CFG_COPIES, {13'd0, copies});
    write_reg(rss_pkg::CFG_JITTER, {8'd0, jitter});
    write_reg(rss_pkg::CFG_SEED, seed);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender back until every predicted transaction has been seen.
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_evts.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic feed_random(int unsigned count);
    int unsigned r;
    int unsigned k;
    in_calm = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_item(1'($urandom_range(0, 1)), 16'($urandom), $urandom);
      end else if (r < 40) begin
        add_item(KIND_SEND, 16'($urandom), clock_ms);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, int'(jitter_m) + 18);
        add_item(KIND_TICK, 16'($urandom), clock_ms);
      end
    end
    do @(negedge clk); while (pending_items.size() != 0);
  endtask

  task automatic random_phase(logic [31:0] start_ms);
    clock_ms = start_ms;
    feed_random(37);
    feed_random(37);
    settle();
  endtask

  initial begin
    int p;
    copies_m = rss_pkg::COPIES_RST;
    jitter_m = rss_pkg::JITTER_RST;
    lfsr_m = rss_pkg::SEED_DEFAULT;
    for (p = 0; p < SLOTS; p++) begin
      slot_left_m[p] = 3'd0;
      slot_tag_m[p] = '0;
      slot_due_m[p] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every slot, overflow the table, then age the copies out, across the time wrap.
    add_item(KIND_SEND, 16'h0000, 32'd0);
    add_item(KIND_SEND, 16'hFFFF, 32'd0);
    add_item(KIND_SEND, 16'h1234, 32'd7);
    add_item(KIND_SEND, 16'hA5A5, 32'd7);
    add_item(KIND_SEND, 16'h5A5A, 32'd0);
    add_item(KIND_TICK, 16'h0000, 32'd0);
    add_item(KIND_TICK, 16'hFFFF, 32'd7);
    add_item(KIND_TICK, 16'h0000, 32'd1000);
    add_item(KIND_TICK, 16'h0000, 32'd1000);
    add_item(KIND_TICK, 16'h0000, 32'd2000);
    add_item(KIND_TICK, 16'h0000, 32'hFFFF_FFFF);
    add_item(KIND_SEND, 16'h8001, 32'hFFFF_FFF0);
    add_item(KIND_TICK, 16'h0000, 32'hFFFF_FFFF);
    add_item(KIND_TICK, 16'h0000, 32'hFFFF_FFFF);
    add_item(KIND_TICK, 16'h0000, 32'd0);
    add_item(KIND_TICK, 16'h0000, 32'hFFFF_FFFF);
    add_item(KIND_SEND, 16'h7FFF, 32'h8000_0000);
    add_item(KIND_TICK, 16'h0000, 32'h7FFF_FFFF);
    add_item(KIND_TICK, 16'h0000, 32'h8000_0000);
    settle();

    configure(3'd0, 8'd0, 16'd0);
    random_phase(32'd0);
    configure(3'd7, 8'd255, 16'hFFFF);
    random_phase($urandom);
    configure(3'd1, 8'd0, 16'd1);
    random_phase(32'hFFFF_FF00);
    for (p = 0; p < 3; p++) begin
      configure(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom));
      random_phase($urandom);
    end

    if (mismatches == 0) begin
      $display("[retransmit_slot_scheduler] OK");
    end else begin
      $display("[retransmit_slot_scheduler] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rss_pkg.sv
rtl/rss_ctrl.sv
rtl/rss_datapath.sv
rtl/retransmit_slot_scheduler.sv
rtl/rss_checker.sv
tb/sv/tb_retransmit_slot_scheduler.sv
